/* hw/rtl/mpv_pkg.sv */
// Package: shared types, constants and SHA-256 helpers for the Merkle proof verifier.
package mpv_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned RoundW = 6;

	localparam logic [CfgIdxW-1:0] RegRoot0 = 2'd0;
	localparam logic [CfgIdxW-1:0] RegRoot1 = 2'd1;
	localparam logic [CfgIdxW-1:0] RegRoot2 = 2'd2;
	localparam logic [CfgIdxW-1:0] RegRoot3 = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_DONE,
		ST_OUT
	} mpv_state_t;

	typedef struct packed {
		logic take;      // latch request into buffers
		logic load_data; // load schedule with data block, vars with IV
		logic load_pad;  // load schedule with padding block, vars with mid hash
		logic round;     // run one round
		logic add;       // fold vars into hash
		logic commit;    // write hash into current hash
	} mpv_cmd_t;

	typedef struct packed {
		logic last_round;
	} mpv_sts_t;

	localparam logic [255:0] InitH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] round_k(input logic [RoundW-1:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* hw/rtl/mpv_ctrl.sv */
// Controller: sequences request capture, the two compressions and the result.
module mpv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [1:0]          word_pos,
	input  logic                final_req,
	output logic                out_valid,
	input  logic                out_stall,
	output mpv_pkg::mpv_cmd_t   cmd,
	input  mpv_pkg::mpv_sts_t   sts
);

	mpv_pkg::mpv_state_t state_q, state_d;
	logic pad_q, fin_q;
	logic accept;

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpv_pkg::ST_IDLE: begin
				if (accept) begin
					if (mode && word_pos == 2'd3) state_d = mpv_pkg::ST_LOAD;
					else if (final_req) state_d = mpv_pkg::ST_OUT;
				end
			end
			mpv_pkg::ST_LOAD: state_d = mpv_pkg::ST_ROUND;
			mpv_pkg::ST_ROUND: if (sts.last_round) state_d = mpv_pkg::ST_ADD;
			mpv_pkg::ST_ADD: state_d = pad_q ? mpv_pkg::ST_DONE : mpv_pkg::ST_LOAD;
			mpv_pkg::ST_DONE: state_d = fin_q ? mpv_pkg::ST_OUT : mpv_pkg::ST_IDLE;
			mpv_pkg::ST_OUT: if (!out_stall) state_d = mpv_pkg::ST_IDLE;
			default: state_d = mpv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			mpv_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			mpv_pkg::ST_LOAD: begin
				cmd.load_data = !pad_q;
				cmd.load_pad = pad_q;
			end
			mpv_pkg::ST_ROUND: cmd.round = 1'b1;
			mpv_pkg::ST_ADD: cmd.add = 1'b1;
			mpv_pkg::ST_DONE: cmd.commit = 1'b1;
			mpv_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpv_pkg::ST_IDLE;
			pad_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fin_q <= final_req;
				pad_q <= 1'b0;
			end else if (state_q == mpv_pkg::ST_ADD) begin
				pad_q <= ~pad_q;
			end
		end
	end

endmodule

/* hw/rtl/mpv_dp.sv */
// Datapath: hash buffers, SHA-256 round unit, schedule window and root compare.
module mpv_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mpv_pkg::mpv_cmd_t           cmd,
	output mpv_pkg::mpv_sts_t           sts,
	input  logic                        mode,
	input  logic [mpv_pkg::WordW-1:0]   word_value,
	input  logic [1:0]                  word_pos,
	input  logic                        we_are_right,
	input  logic [4*mpv_pkg::WordW-1:0] root,
	output logic                        root_match
);

	logic [mpv_pkg::WordW-1:0] cur_q [4];
	logic [mpv_pkg::WordW-1:0] sib_q [4];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [mpv_pkg::RoundW-1:0] rnd_q;
	logic right_q;

	logic [255:0] lo, hi;
	logic [31:0] wt, s0, s1, bs0, bs1, ch, mj, t1, t2;

	assign lo = right_q ? {sib_q[0], sib_q[1], sib_q[2], sib_q[3]}
	                    : {cur_q[0], cur_q[1], cur_q[2], cur_q[3]};
	assign hi = right_q ? {cur_q[0], cur_q[1], cur_q[2], cur_q[3]}
	                    : {sib_q[0], sib_q[1], sib_q[2], sib_q[3]};

	// rolling window: w_q[0] is the word for this round
	assign s0 = mpv_pkg::rotr(w_q[1], 7) ^ mpv_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = mpv_pkg::rotr(w_q[14], 17) ^ mpv_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wt = w_q[0];
	assign bs1 = mpv_pkg::rotr(v_q[4], 6) ^ mpv_pkg::rotr(v_q[4], 11) ^ mpv_pkg::rotr(v_q[4], 25);
	assign bs0 = mpv_pkg::rotr(v_q[0], 2) ^ mpv_pkg::rotr(v_q[0], 13) ^ mpv_pkg::rotr(v_q[0], 22);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + bs1 + ch + mpv_pkg::round_k(rnd_q) + wt;
	assign t2 = bs0 + mj;

	assign sts.last_round = (rnd_q == {mpv_pkg::RoundW{1'b1}});

	assign root_match = ({cur_q[0], cur_q[1], cur_q[2], cur_q[3]} == root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cur_q[i] <= '0;
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.take && !mode) cur_q[word_pos] <= word_value;
			if (cmd.load_data || cmd.load_pad) begin
				rnd_q <= '0;
				for (int i = 0; i < 8; i++)
					v_q[i] <= cmd.load_data ? mpv_pkg::InitH[255-32*i -: 32] : h_q[i];
			end
			if (cmd.round) begin
				rnd_q <= rnd_q + 1'b1;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (cmd.commit)
				for (int i = 0; i < 4; i++) cur_q[i] <= {h_q[2*i], h_q[2*i+1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mode) begin
			sib_q[word_pos] <= word_value;
			right_q <= we_are_right;
		end
		if (cmd.load_data) begin
			for (int i = 0; i < 8; i++) begin
				w_q[i] <= lo[255-32*i -: 32];
				w_q[8+i] <= hi[255-32*i -: 32];
				h_q[i] <= mpv_pkg::InitH[255-32*i -: 32];
			end
		end
		if (cmd.load_pad) begin
			w_q[0] <= 32'h80000000;
			for (int i = 1; i < 15; i++) w_q[i] <= '0;
			w_q[15] <= 32'd512;
		end
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
		end
		if (cmd.add)
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
	end

endmodule

/* hw/rtl/merkle_proof_verifier.sv */
// Top level: Merkle inclusion proof checker over SHA-256.
// Usage: send hash words on the input channel (valid/stall). Leaf words
// (mode 0) load the current hash, one word per request. Sibling words
// (mode 1) are buffered; the request with word_pos 3 starts the pair hash:
// two SHA-256 compressions on one shared round unit, each a load step, the
// rounds and an add step, followed by a commit step; that request holds the
// input stalled until the commit is done.
// A request with final_req set yields one result on the output channel
// (valid/stall) carrying root_match, the compare of the current hash with
// the four root registers; the result waits while stall is high and no new
// request is taken until it has gone.
// Root registers are written through cfg_we/cfg_index/cfg_data while idle;
// the user is bound to that, the block does not enforce it. Reset clears the
// current hash, the root registers and the controller, leaving the block ready.
module merkle_proof_verifier (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic [mpv_pkg::WordW-1:0] word_value,
	input  logic [1:0]                word_pos,
	input  logic                      we_are_right,
	input  logic                      final_req,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      root_match,
	input  logic                      cfg_we,
	input  logic [mpv_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [mpv_pkg::WordW-1:0] cfg_data
);

	mpv_pkg::mpv_cmd_t cmd;
	mpv_pkg::mpv_sts_t sts;
	logic [mpv_pkg::WordW-1:0] root_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) root_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mpv_pkg::RegRoot0: root_q[0] <= cfg_data;
				mpv_pkg::RegRoot1: root_q[1] <= cfg_data;
				mpv_pkg::RegRoot2: root_q[2] <= cfg_data;
				mpv_pkg::RegRoot3: root_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	mpv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .word_pos(word_pos), .final_req(final_req),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));

	mpv_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .mode(mode),
		.word_value(word_value), .word_pos(word_pos), .we_are_right(we_are_right),
		.root({root_q[0], root_q[1], root_q[2], root_q[3]}), .root_match(root_match));

endmodule

/* tb/merkle_proof_verifier_tb.sv */
// Testbench for the Merkle proof verifier: proof streams checked against a SHA-256 predictor.
`timescale 1ns / 1ps

module merkle_proof_verifier_tb;

	localparam int WatchdogLimit = 20000;
	localparam int LongHold = 1200;
	localparam int SettleCycles = 160;

	class merkle_sb;
		static bit [31:0] rk[64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		static bit [255:0] iv = {
			32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

		bit [255:0] cur_hash;
		bit [255:0] sib_words;
		bit [255:0] root;
		bit match_q[$];
		int errors;

		static function bit [31:0] ror(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		static function bit [255:0] compress(bit [255:0] h, bit [511:0] blk);
			bit [31:0] w[64];
			bit [31:0] v[8];
			bit [31:0] t1, t2;
			bit [255:0] res;
			for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
			for (int i = 16; i < 64; i++)
				w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
			for (int i = 0; i < 8; i++) v[i] = h[255-32*i -: 32];
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk[t] + w[t];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) res[255-32*i -: 32] = v[i] + h[255-32*i -: 32];
			return res;
		endfunction

		static function bit [255:0] pair_digest(bit [255:0] node, bit [255:0] sib, bit right);
			bit [255:0] h;
			h = compress(iv, right ? {sib, node} : {node, sib});
			return compress(h, {32'h80000000, 448'b0, 32'd512});
		endfunction

		function void set_root(int idx, bit [63:0] v);
			root[255-64*idx -: 64] = v;
		endfunction

		function void note_request(bit m, bit [63:0] w, bit [1:0] p, bit r, bit f);
			if (!m) cur_hash[255-64*p -: 64] = w;
			else begin
				sib_words[255-64*p -: 64] = w;
				if (p == 2'd3) cur_hash = pair_digest(cur_hash, sib_words, r);
			end
			if (f) match_q.push_back(cur_hash == root);
		endfunction

		function void check_result(bit got, realtime t);
			bit want;
			if (match_q.size() == 0) begin
				$display("%0t: unexpected result root_match=%0b", t, got);
				errors++;
				return;
			end
			want = match_q.pop_front();
			if (got !== want) begin
				$display("%0t: root_match expected %0b actual %0b", t, want, got);
				errors++;
			end
		endfunction

		function int pending();
			return match_q.size();
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, mode, we_are_right, final_req;
	logic [mpv_pkg::WordW-1:0] word_value, cfg_data;
	logic [1:0] word_pos;
	logic out_valid, out_stall, root_match, cfg_we;
	logic [mpv_pkg::CfgIdxW-1:0] cfg_index;

	merkle_sb sb = new();
	int idle_pct, stall_pct;
	int hold_id, hold_seen, hold_left, quiet;

	merkle_proof_verifier u_top (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_seen != hold_id) begin
			hold_seen <= hold_id;
			hold_left <= LongHold;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(root_match, $realtime);
		if (!arst_n || (out_valid && !out_stall) || (in_valid && !in_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WatchdogLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_req(bit m, bit [63:0] w, bit [1:0] p, bit r, bit f);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		word_value <= w;
		word_pos <= p;
		we_are_right <= r;
		final_req <= f;
		do @(posedge clk); while (in_stall);
		sb.note_request(m, w, p, r, f);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// a sibling request without a result may still be hashing
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_root(bit [255:0] v);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[mpv_pkg::CfgIdxW-1:0];
			cfg_data <= v[255-64*i -: 64];
			@(posedge clk);
			sb.set_root(i, v[255-64*i -: 64]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic bit [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [255:0] rnd256();
		return {rnd64(), rnd64(), rnd64(), rnd64()};
	endfunction

	// leaf then siblings, final on the last request; scramble word order when asked
	task automatic send_proof(bit [255:0] leaf, bit [255:0] sibs[$], bit rights[$], bit scramble);
		int order[4];
		int n;
		bit [1:0] p;
		n = sibs.size();
		for (int k = 0; k < 4; k++) order[k] = k;
		if (scramble) order.shuffle();
		for (int k = 0; k < 4; k++) begin
			p = 2'(order[k]);
			send_req(1'b0, leaf[255-64*p -: 64], p, 1'($urandom_range(1)),
				(n == 0) && (k == 3));
		end
		for (int s = 0; s < n; s++) begin
			for (int k = 0; k < 4; k++) begin
				p = scramble ? 2'(order[k]) : 2'(k);
				send_req(1'b1, sibs[s][255-64*p -: 64], p, rights[s],
					(s == n - 1) && (k == 3));
			end
		end
	endtask

	initial begin
		bit [255:0] leaf, root_v;
		bit [255:0] sibs[$];
		bit rights[$];
		int nsib, sent;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= 1'b0;
		word_value <= '0;
		word_pos <= '0;
		we_are_right <= 1'b0;
		final_req <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mpv_pkg::RegRoot0;
		cfg_data <= '0;
		out_stall <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_id = 0;
		hold_seen = 0;
		hold_left = 0;
		quiet = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero leaf against the reset root, extreme siblings, finals mid-proof
		for (int k = 0; k < 4; k++) send_req(1'b0, '0, 2'(k), 1'b0, k == 3);
		for (int k = 0; k < 3; k++) send_req(1'b1, '1, 2'(k), 1'b1, k == 1);
		send_req(1'b1, '1, 2'd3, 1'b0, 1'b1);
		for (int k = 3; k >= 0; k--) send_req(1'b1, rnd64(), 2'(k), 1'b1, 1'b0);
		send_req(1'b1, rnd64(), 2'd3, 1'b1, 1'b1);
		send_req(1'b0, '1, 2'd2, 1'b0, 1'b1);
		for (int k = 0; k < 4; k++) send_req(1'b0, '1, 2'(k), 1'b0, k == 3);
		drain();
		write_root('1);
		send_req(1'b0, '0, 2'd1, 1'b1, 1'b1);
		send_req(1'b0, '1, 2'd1, 1'b0, 1'b1);
		send_req(1'b1, '0, 2'd3, 1'b1, 1'b1);

		for (int ph = 0; ph < 20; ph++) begin
			drain();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 87; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 87; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			// first proof of the phase decides the root when a match is wanted
			leaf = rnd256();
			sibs.delete();
			rights.delete();
			nsib = $urandom_range(3);
			root_v = leaf;
			for (int s = 0; s < nsib; s++) begin
				sibs.push_back(rnd256());
				rights.push_back(1'($urandom_range(1)));
				root_v = merkle_sb::pair_digest(root_v, sibs[s], rights[s]);
			end
			case (ph % 5)
				1: write_root('0);
				2: write_root('1);
				3: write_root(rnd256());
				default: write_root(root_v);
			endcase
			if (ph == 2 || ph == 13) hold_id++;
			send_proof(leaf, sibs, rights, 1'b0);
			sent = 4 * (nsib + 1);
			while (sent < 75) begin
				if ($urandom_range(99) < 80) begin
					sibs.delete();
					rights.delete();
					nsib = ($urandom_range(9) == 0) ? $urandom_range(6) : $urandom_range(2);
					for (int s = 0; s < nsib; s++) begin
						sibs.push_back(rnd256());
						rights.push_back(1'($urandom_range(1)));
					end
					send_proof(rnd256(), sibs, rights, $urandom_range(3) == 0);
					sent += 4 * (nsib + 1);
				end else begin
					repeat ($urandom_range(1, 4)) begin
						send_req(1'($urandom_range(1)), rnd64(), 2'($urandom_range(3)),
							1'($urandom_range(1)), $urandom_range(3) == 0);
						sent++;
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
